[sv/aesks_pkg.sv]
// aes-128 key schedule package: s-box table, round constants, sizes
// no dependencies; used by aes128_key_expansion
`timescale 1ns / 1ps

package aesks_pkg;

    localparam int KEY_BYTES = 16;
    localparam logic [3:0] LAST_ROUND = 4'd10;

    typedef logic [7:0] byte_t;
    typedef logic [3:0] round_t;
    typedef logic [3:0] byte_idx_t;

    typedef struct packed {
        logic      busy;
        round_t    round;
        byte_idx_t idx;
    } ctrl_t;

    localparam byte_t SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    // round constant used when building round key r
    function automatic byte_t rcon(input round_t r);
        byte_t v;
        unique case (r)
            4'd1:    v = 8'h01;
            4'd2:    v = 8'h02;
            4'd3:    v = 8'h04;
            4'd4:    v = 8'h08;
            4'd5:    v = 8'h10;
            4'd6:    v = 8'h20;
            4'd7:    v = 8'h40;
            4'd8:    v = 8'h80;
            4'd9:    v = 8'h1b;
            4'd10:   v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

[sv/aes128_key_expansion.sv]
// aes-128 key expansion, byte-serial: one schedule byte per clock unless a finished round key is held
// depends on aesks_pkg (s-box table, round constants)
`timescale 1ns / 1ps

// Takes one 128-bit cipher key per request and returns the 11 round keys,
// round 0 first, with m_last_round set on round 10. The schedule is computed
// one byte per clock through a 16-byte shift register with a single s-box
// lookup, held only while a finished round key waits for the output
// register. A taken key is registered in the shift line and control state
// before round 0 is loaded into the output register; the next key can be
// taken once round 10 is loaded there. The output register lets the next
// round be computed while a round key waits for m_ready; a stall that lasts
// until the next round key is complete holds the engine. One key at a time.
module aes128_key_expansion (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_key_high,
    input  logic [63:0] s_key_low,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_round_number,
    output logic [63:0] m_round_key_high,
    output logic [63:0] m_round_key_low,
    output logic        m_last_round
);

    // byte 0 of the key sits at index 0, the head of the shift line
    logic [0:aesks_pkg::KEY_BYTES-1][7:0] sreg_reg, sreg_next;
    aesks_pkg::ctrl_t ctrl_reg, ctrl_next;

    logic                      out_valid_reg, out_valid_next;
    aesks_pkg::round_t         out_round_reg, out_round_next;
    logic [127:0]              out_key_reg, out_key_next;
    logic                      out_last_reg, out_last_next;

    logic             accept;
    logic             emit;
    logic             out_free;
    logic             step;
    aesks_pkg::byte_t tap;
    aesks_pkg::byte_t sub;
    aesks_pkg::byte_t t;
    aesks_pkg::byte_t new_byte;
    aesks_pkg::round_t next_round;

    assign s_ready  = !ctrl_reg.busy;
    assign accept   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;
    // a full round key sits in the shift line when the byte index is zero
    assign emit     = ctrl_reg.busy && (ctrl_reg.idx == '0) && out_free;
    assign step     = ctrl_reg.busy && ((ctrl_reg.idx != '0)
                      || (emit && (ctrl_reg.round != aesks_pkg::LAST_ROUND)));
    assign next_round = ctrl_reg.round + 4'd1;

    // first word bytes take rotated last word: old bytes 13,14,15 then 12
    always_comb begin
        if (ctrl_reg.idx == 4'd3) begin
            tap = sreg_reg[9];
        end else begin
            tap = sreg_reg[13];
        end
    end

    assign sub = aesks_pkg::SBOX[tap];

    always_comb begin
        priority if (ctrl_reg.idx == '0) begin
            t = sub ^ aesks_pkg::rcon(next_round);
        end else if (ctrl_reg.idx < 4'd4) begin
            t = sub;
        end else begin
            // new byte four places back
            t = sreg_reg[12];
        end
    end

    assign new_byte = sreg_reg[0] ^ t;

    always_comb begin
        sreg_next      = sreg_reg;
        ctrl_next      = ctrl_reg;
        out_valid_next = out_valid_reg;
        out_round_next = out_round_reg;
        out_key_next   = out_key_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        if (accept) begin
            sreg_next      = {s_key_high, s_key_low};
            ctrl_next.busy  = 1'b1;
            ctrl_next.round = '0;
            ctrl_next.idx   = '0;
        end

        if (emit) begin
            out_valid_next = 1'b1;
            out_round_next = ctrl_reg.round;
            out_key_next   = sreg_reg;
            out_last_next  = (ctrl_reg.round == aesks_pkg::LAST_ROUND);
            if (ctrl_reg.round == aesks_pkg::LAST_ROUND) begin
                ctrl_next.busy = 1'b0;
            end
        end

        if (step) begin
            sreg_next     = {sreg_reg[1:aesks_pkg::KEY_BYTES-1], new_byte};
            ctrl_next.idx = ctrl_reg.idx + 4'd1;
            if (ctrl_reg.idx == 4'(aesks_pkg::KEY_BYTES - 1)) begin
                ctrl_next.round = next_round;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            ctrl_reg      <= ctrl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sreg_reg      <= sreg_next;
        out_round_reg <= out_round_next;
        out_key_reg   <= out_key_next;
        out_last_reg  <= out_last_next;
    end

    assign m_valid          = out_valid_reg;
    assign m_round_number   = out_round_reg;
    assign m_round_key_high = out_key_reg[127:64];
    assign m_round_key_low  = out_key_reg[63:0];
    assign m_last_round     = out_last_reg;

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> ctrl_reg.busy && ctrl_reg.round == '0 && ctrl_reg.idx == '0)
        else $error("request did not start round zero");

    a_round_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_reg.busy |-> ctrl_reg.round <= aesks_pkg::LAST_ROUND)
        else $error("round counter past last round");

    a_byte_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_reg.busy && ctrl_reg.idx != '0
        |=> ctrl_reg.idx == 4'($past(ctrl_reg.idx) + 4'd1))
        else $error("byte index did not advance");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && ctrl_reg.round == aesks_pkg::LAST_ROUND
        |=> !ctrl_reg.busy && m_valid && m_last_round)
        else $error("last round key did not end the run");

    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_round == (m_round_number == aesks_pkg::LAST_ROUND)))
        else $error("last flag disagrees with round number");

endmodule
